@@ rtl/core/dca_pkg.sv @@
// ============================================================================
// dca_pkg
// Shared types and codes for the descriptor chain allocator.
// ============================================================================
`default_nettype none

package dca_pkg;

  localparam int unsigned HEAD_W   = 8;
  localparam int unsigned SLOT_W   = 8;
  localparam int unsigned STATUS_W = 2;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NOSPACE = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_RANGE   = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_FREED   = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PICK,
    ST_TAIL,
    ST_WALK
  } state_t;

endpackage : dca_pkg

`default_nettype wire

@@ rtl/core/dca_ffs.sv @@
// ============================================================================
// dca_ffs
// Lowest-set-bit finder over the candidate free mask.
// ============================================================================
`default_nettype none

module dca_ffs #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned IDX_W = 3
) (
  input  wire logic [WIDTH-1:0] bits,
  output logic                  found,
  output logic [IDX_W-1:0]      idx
);

  // scan from the top so the lowest set bit wins
  always_comb begin
    found = 1'b0;
    idx   = '0;
    for (int i = WIDTH - 1; i >= 0; i--) begin
      if (bits[i]) begin
        found = 1'b1;
        idx   = IDX_W'(i);
      end
    end
  end

endmodule : dca_ffs

`default_nettype wire

@@ rtl/core/descriptor_chain_allocator_core.sv @@
// ============================================================================
// descriptor_chain_allocator_core
// Descriptor pool with free bitmap and link store: allocates chains of the
// lowest free descriptors and frees chains by walking their links.
// ============================================================================
//
//  channel   signals                          direction  handshake
//  --------  -------------------------------  ---------  -------------------------
//  request   start, busy, opcode, head        in         taken when start && !busy
//  result    done, status, slot0..slot2       out        done high one cycle, no stall
//
//  Sequence: after the request is taken, allocate runs CHAIN_LEN search steps
//  in ST_PICK and then a commit step in ST_TAIL; free visits the chain entries
//  in turn in ST_WALK. The free walk is bound by the link memory: one read per
//  entry, the next address coming straight off the read data. done rises on the
//  edge after the last working cycle; busy drops at that same edge.
//  Reset (rst, synchronous) marks all descriptors free. Link entries need no
//  clearing: every entry is written at allocation before a walk uses it.
//  The receiver cannot stall; done is high for a single cycle, and status and slots hold until the next result.
//
`default_nettype none

module descriptor_chain_allocator_core #(
  parameter int unsigned POOL_SIZE = 8,
  parameter int unsigned CHAIN_LEN = 3
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire logic                            opcode,
  input  wire logic [dca_pkg::HEAD_W-1:0]      head,
  output logic                                 done,
  output logic [dca_pkg::STATUS_W-1:0]         status,
  output logic [dca_pkg::SLOT_W-1:0]           slot0,
  output logic [dca_pkg::SLOT_W-1:0]           slot1,
  output logic [dca_pkg::SLOT_W-1:0]           slot2
);

  import dca_pkg::*;

  localparam int unsigned IDX_W  = $clog2(POOL_SIZE);
  localparam int unsigned LINK_W = IDX_W + 1;           // {has_next, next}
  localparam int unsigned CNT_W  = (CHAIN_LEN > 1) ? $clog2(CHAIN_LEN) : 1;
  localparam logic [CNT_W-1:0]  K_LAST     = CNT_W'(CHAIN_LEN - 1);
  localparam logic [IDX_W-1:0]  STEP_LAST  = IDX_W'(POOL_SIZE - 1);
  localparam logic [HEAD_W:0]   POOL_LIMIT = (HEAD_W + 1)'(POOL_SIZE);

  // --------------------------------------------------------------------------
  // State
  // --------------------------------------------------------------------------
  state_t                state, state_next;
  logic [POOL_SIZE-1:0]  free_map;      // 1 = free
  logic [POOL_SIZE-1:0]  mask;          // free map minus picks of this request
  logic [CNT_W-1:0]      k;             // pick counter
  logic [IDX_W-1:0]      prev;          // last picked descriptor
  logic [IDX_W-1:0]      picks [CHAIN_LEN];
  logic [HEAD_W-1:0]     cur;           // walk position
  logic [IDX_W-1:0]      steps;         // walk cap counter

  // link store: one write port, one read port, registered read
  logic [LINK_W-1:0]     link_mem [POOL_SIZE];
  logic [LINK_W-1:0]     rd_data;
  logic [IDX_W-1:0]      rd_addr;
  logic                  mem_we;
  logic [IDX_W-1:0]      mem_waddr;
  logic [LINK_W-1:0]     mem_wdata;

  // lowest free search
  logic                  ffs_found;
  logic [IDX_W-1:0]      ffs_idx;

  dca_ffs #(
    .WIDTH (POOL_SIZE),
    .IDX_W (IDX_W)
  ) u_ffs (
    .bits  (mask),
    .found (ffs_found),
    .idx   (ffs_idx)
  );

  // --------------------------------------------------------------------------
  // Walk decode
  // --------------------------------------------------------------------------
  logic             accept;
  logic [IDX_W-1:0] cur_idx;
  logic             range_bad;
  logic             already_free;
  logic             link_more;
  logic [IDX_W-1:0] link_next;
  logic             walk_end;

  assign accept       = start && !busy;
  assign cur_idx      = cur[IDX_W-1:0];
  assign range_bad    = !({1'b0, cur} < POOL_LIMIT);
  assign already_free = free_map[cur_idx];
  assign link_more    = rd_data[IDX_W];
  assign link_next    = rd_data[IDX_W-1:0];
  assign walk_end     = range_bad || already_free || !link_more || (steps == STEP_LAST);

  // --------------------------------------------------------------------------
  // Next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) state_next = (opcode == OP_ALLOC) ? ST_PICK : ST_WALK;
      end
      ST_PICK: begin
        if (!ffs_found)       state_next = ST_IDLE;
        else if (k == K_LAST) state_next = ST_TAIL;
      end
      ST_TAIL: state_next = ST_IDLE;
      ST_WALK: begin
        if (walk_end) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Outputs of the controller
  // --------------------------------------------------------------------------
  logic                res_valid;
  logic [STATUS_W-1:0] res_status;
  logic                res_slots;     // show allocated slots
  logic                free_set;      // mark cur free
  logic                pick_take;     // record a pick
  logic                walk_adv;      // step to the next link

  always_comb begin
    busy       = (state != ST_IDLE);
    res_valid  = 1'b0;
    res_status = STATUS_OK;
    res_slots  = 1'b0;
    free_set   = 1'b0;
    pick_take  = 1'b0;
    walk_adv   = 1'b0;
    mem_we     = 1'b0;
    mem_waddr  = prev;
    mem_wdata  = {1'b1, ffs_idx};
    rd_addr    = cur_idx;
    case (state)
      ST_IDLE: begin
        rd_addr = head[IDX_W-1:0];
      end
      ST_PICK: begin
        if (!ffs_found) begin
          res_valid  = 1'b1;
          res_status = STATUS_NOSPACE;
        end else begin
          pick_take = 1'b1;
          // link the previous pick to this one; harmless if the request
          // later runs out of space, since the entry stays free
          mem_we    = (k != '0);
        end
      end
      ST_TAIL: begin
        mem_we     = 1'b1;
        mem_waddr  = prev;
        mem_wdata  = '0;
        res_valid  = 1'b1;
        res_slots  = 1'b1;
      end
      ST_WALK: begin
        if (range_bad) begin
          res_valid  = 1'b1;
          res_status = STATUS_RANGE;
        end else if (already_free) begin
          res_valid  = 1'b1;
          res_status = STATUS_FREED;
        end else begin
          free_set = 1'b1;
          if (walk_end) begin
            res_valid = 1'b1;
          end else begin
            walk_adv = 1'b1;
            rd_addr  = link_next;
          end
        end
      end
      default: ;
    endcase
  end

  // --------------------------------------------------------------------------
  // Link memory
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (mem_we) link_mem[mem_waddr] <= mem_wdata;
    rd_data <= link_mem[rd_addr];
  end

  // --------------------------------------------------------------------------
  // Control and datapath registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      free_map <= '1;
      done     <= 1'b0;
    end else begin
      state <= state_next;
      done  <= res_valid;
      if (free_set)               free_map[cur_idx] <= 1'b1;
      if (state == ST_TAIL)       free_map <= mask;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mask  <= free_map;
      k     <= '0;
      cur   <= head;
      steps <= '0;
    end
    if (pick_take) begin
      picks[k]      <= ffs_idx;
      prev          <= ffs_idx;
      mask[ffs_idx] <= 1'b0;
      k             <= k + CNT_W'(1);
    end
    if (walk_adv) begin
      cur   <= HEAD_W'(link_next);
      steps <= steps + IDX_W'(1);
    end
    if (res_valid) begin
      status <= res_status;
      if (res_slots) begin
        slot0 <= SLOT_W'(picks[0]);
        if (CHAIN_LEN > 1) slot1 <= SLOT_W'(picks[1]);
        else slot1 <= '0;
        // last pick was registered at the edge into the tail cycle
        if (CHAIN_LEN > 2) slot2 <= SLOT_W'(picks[2]);
        else slot2 <= '0;
      end else begin
        slot0 <= '0;
        slot1 <= '0;
        slot2 <= '0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_done_single : assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held for two cycles");

  a_nospace_real : assert property (@(posedge clk) disable iff (rst)
    (done && status == STATUS_NOSPACE) |-> ($countones(free_map) < CHAIN_LEN))
    else $error("no-space reported with enough free descriptors");

  a_mask_subset : assert property (@(posedge clk) disable iff (rst)
    (state == ST_PICK || state == ST_TAIL) |-> ((mask & ~free_map) == '0))
    else $error("search mask holds a descriptor that is not free");

  a_done_after_work : assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state) != ST_IDLE)
    else $error("result without a request in progress");

endmodule : descriptor_chain_allocator_core

`default_nettype wire

@@ tb/sv/descriptor_chain_allocator_core_tb.sv @@
// ============================================================================
// descriptor_chain_allocator_core_tb
// Drives allocate and free requests into the descriptor pool, keeps its own
// copy of the free map and link store, and checks every result strobe
// against the predicted status and slots in request order.
// ============================================================================
`default_nettype none

module descriptor_chain_allocator_core_tb;
  import dca_pkg::*;

  localparam int POOL            = 8;
  localparam int CHAIN           = 3;
  localparam int ITEMS_PER_PHASE = 334;
  localparam int DRAIN_CYCLES    = 16;
  localparam int TIMEOUT_CYCLES  = 200000;
  localparam int MAX_PRINTS      = 40;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot0;
    logic [SLOT_W-1:0]   slot1;
    logic [SLOT_W-1:0]   slot2;
  } outcome_t;

  // Pool mirror plus the queue of outcomes still owed by the block.
  class pool_tracker;
    bit          is_free [POOL];
    int unsigned link_to [POOL];
    bit          linked  [POOL];
    int unsigned live_heads[$];
    outcome_t    pending_outcomes[$];
    int          errors;

    function new();
      for (int i = 0; i < POOL; i++) begin
        is_free[i] = 1'b1;
        link_to[i] = 0;
        linked[i]  = 1'b0;
      end
      errors = 0;
    endfunction

    // Lowest free descriptors, linked in ascending order.
    function outcome_t claim_chain();
      int unsigned picked[$];
      outcome_t    res;
      res = '0;
      for (int unsigned i = 0; i < POOL && picked.size() < CHAIN; i++)
        if (is_free[i]) picked.push_back(i);
      if (picked.size() < CHAIN) begin
        res.status = STATUS_NOSPACE;
        return res;
      end
      for (int i = 0; i < CHAIN; i++) begin
        is_free[picked[i]] = 1'b0;
        linked[picked[i]]  = (i + 1 < CHAIN);
        link_to[picked[i]] = (i + 1 < CHAIN) ? picked[i + 1] : 0;
      end
      res.status = STATUS_OK;
      res.slot0  = SLOT_W'(picked[0]);
      if (CHAIN > 1) res.slot1 = SLOT_W'(picked[1]);
      if (CHAIN > 2) res.slot2 = SLOT_W'(picked[2]);
      live_heads.push_back(picked[0]);
      return res;
    endfunction

    // Walk from the given head; entries freed before an error stay freed.
    function outcome_t release_chain(int unsigned from);
      outcome_t    res;
      int unsigned cur;
      int unsigned nxt;
      bit          more;
      res        = '0;
      res.status = STATUS_OK;
      cur        = from;
      for (int i = live_heads.size() - 1; i >= 0; i--)
        if (live_heads[i] == from) live_heads.delete(i);
      for (int steps = 0; steps < POOL; steps++) begin
        if (cur >= POOL) begin
          res.status = STATUS_RANGE;
          break;
        end
        if (is_free[cur]) begin
          res.status = STATUS_FREED;
          break;
        end
        more         = linked[cur];
        nxt          = link_to[cur];
        linked[cur]  = 1'b0;
        link_to[cur] = 0;
        is_free[cur] = 1'b1;
        if (!more) break;
        cur = nxt;
      end
      return res;
    endfunction

    function void note_request(logic op, logic [HEAD_W-1:0] h);
      if (op == OP_ALLOC) pending_outcomes.push_back(claim_chain());
      else pending_outcomes.push_back(release_chain(h));
    endfunction

    task report_mismatch(string what);
      if (errors < MAX_PRINTS) $display("MISMATCH @%0t: %s", $time, what);
      errors++;
    endtask

    task check_result(logic [STATUS_W-1:0] st, logic [SLOT_W-1:0] s0,
                      logic [SLOT_W-1:0] s1, logic [SLOT_W-1:0] s2);
      outcome_t want;
      if (pending_outcomes.size() == 0) begin
        report_mismatch($sformatf("unexpected result, status %0d", st));
        return;
      end
      want = pending_outcomes.pop_front();
      if (st !== want.status)
        report_mismatch($sformatf("status %0d, want %0d", st, want.status));
      if (s0 !== want.slot0)
        report_mismatch($sformatf("slot0 %0d, want %0d", s0, want.slot0));
      if (s1 !== want.slot1)
        report_mismatch($sformatf("slot1 %0d, want %0d", s1, want.slot1));
      if (s2 !== want.slot2)
        report_mismatch($sformatf("slot2 %0d, want %0d", s2, want.slot2));
    endtask
  endclass

  logic                clk    = 1'b0;
  logic                rst    = 1'b1;
  logic                start  = 1'b0;
  logic                opcode = OP_ALLOC;
  logic [HEAD_W-1:0]   head   = '0;
  logic                busy;
  logic                done;
  logic [STATUS_W-1:0] status;
  logic [SLOT_W-1:0]   slot0;
  logic [SLOT_W-1:0]   slot1;
  logic [SLOT_W-1:0]   slot2;

  pool_tracker ledger = new();

  descriptor_chain_allocator_core #(
    .POOL_SIZE (POOL),
    .CHAIN_LEN (CHAIN)
  ) uut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .opcode (opcode),
    .head   (head),
    .done   (done),
    .status (status),
    .slot0  (slot0),
    .slot1  (slot1),
    .slot2  (slot2)
  );

  always #2 clk = ~clk;

  // Results cannot be held off: take each strobe as it comes.
  always @(posedge clk) begin
    if (!rst && done) ledger.check_result(status, slot0, slot1, slot2);
  end

  // start stays high from one item to the next; only idling lowers it.
  task automatic issue(input logic op, input logic [HEAD_W-1:0] h);
    start  <= 1'b1;
    opcode <= op;
    head   <= h;
    do @(posedge clk); while (busy);
    ledger.note_request(op, h);
  endtask

  task automatic hold_off();
    start <= 1'b0;
    @(posedge clk);
  endtask

  task automatic settle();
    start <= 1'b0;
    do @(posedge clk); while (ledger.pending_outcomes.size() != 0);
  endtask

  // Mostly well-formed alloc/free of live chains, some stray and mid-chain frees.
  task automatic pick_request(output logic op, output logic [HEAD_W-1:0] h);
    int roll;
    roll = $urandom_range(99);
    h    = HEAD_W'($urandom_range(255));
    if (roll < 8) begin
      op = OP_FREE;
    end else if (roll < 16) begin
      op = OP_FREE;
      h  = HEAD_W'($urandom_range(POOL - 1));
    end else if (roll < 55 || ledger.live_heads.size() == 0) begin
      op = OP_ALLOC;
    end else begin
      op = OP_FREE;
      h  = HEAD_W'(ledger.live_heads[$urandom_range(ledger.live_heads.size() - 1)]);
    end
  endtask

  initial begin
    int                idle_pct;
    logic              op;
    logic [HEAD_W-1:0] h;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // free on an empty pool, then out-of-range heads
    issue(OP_FREE, 8'd0);
    issue(OP_FREE, 8'd255);
    issue(OP_FREE, 8'd8);
    issue(OP_FREE, 8'h80);
    issue(OP_FREE, 8'h55);
    // two chains, then no space with two left
    issue(OP_ALLOC, 8'hAA);
    issue(OP_ALLOC, 8'h00);
    issue(OP_ALLOC, 8'hFF);
    issue(OP_FREE, 8'd3);
    issue(OP_FREE, 8'd3);
    // free from the middle of a chain, then alloc into the holes
    issue(OP_FREE, 8'd1);
    issue(OP_ALLOC, 8'd0);
    // stale link from 0 runs into the newer chain
    issue(OP_FREE, 8'd0);
    issue(OP_FREE, 8'd7);
    issue(OP_ALLOC, 8'd0);
    issue(OP_ALLOC, 8'd0);
    issue(OP_ALLOC, 8'd0);
    issue(OP_FREE, 8'd4);
    issue(OP_FREE, 8'd2);
    issue(OP_FREE, 8'd0);
    issue(OP_ALLOC, 8'd0);

    for (int phase = 0; phase < 3; phase++) begin
      idle_pct = (phase == 0) ? 17 : (phase == 1) ? 74 : 0;
      settle();
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        while ($urandom_range(99) < idle_pct) hold_off();
        pick_request(op, h);
        issue(op, h);
      end
    end

    start <= 1'b0;
    while (ledger.pending_outcomes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (ledger.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_CYCLES * 4);
    $display("Some tests failed");
    $finish;
  end

endmodule

`default_nettype wire
